// ===== rtl/core/circular_queue_with_walk_core_defines.svh =====
// Assertion macros for the circular queue with walk core.
`ifndef CIRCULAR_QUEUE_WITH_WALK_CORE_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_WALK_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define CQW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CQW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CQW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CQW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/cqw_pkg.sv =====
// Shared types and constants for the circular queue with walk core.
package cqw_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int RESULT_LIMIT  = 16;
    localparam int CAP_W         = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] ACT_ENQ  = 2'd0;
    localparam logic [1:0] ACT_DEQ  = 2'd1;
    localparam logic [1:0] ACT_LIST = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic               last;
    } t_out_item;

endpackage

// ===== rtl/core/circular_queue_with_walk_core.sv =====
// Circular queue of signed words with enqueue, dequeue and an oldest-to-newest walk.
//
// The block takes one request item at a time over a valid/stall channel and returns its
// results over a second valid/stall channel. Enqueue stores a word at the tail and returns
// one item (ok, or full with the word dropped). Dequeue returns the oldest word, or one
// empty item. List walks the stored words from oldest to newest, one result item per word
// with last set on the newest, leaving the queue untouched; an empty queue gives a single
// empty item. Action code 3 is ignored and gives no result. The capacity register sets how
// many slots wrap (zero acts as one, values above the storage depth or 16 saturate), and
// writing it empties the queue; write it only while no request is in flight. An enqueue
// (or any full/empty answer) goes from the idle state straight to the output state; a
// dequeue passes through the read state first, and a list passes through the read and
// output states for each word. This follows from the single storage read port, whose
// read data is registered before it reaches the output register, and from one shared
// index-advance unit that steps the tail, head and walk pointer in turn. Output stall
// holds the result. No clearing pass runs after reset: slots are only read once written.
module circular_queue_with_walk_core #(
    parameter int DEPTH = cqw_pkg::DEPTH_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [cqw_pkg::CAP_W-1:0]  i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  cqw_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output cqw_pkg::t_out_item         o_out_item
);
    import cqw_pkg::*;

    `include "circular_queue_with_walk_core_defines.svh"

    // Slots actually reachable: capacity never exceeds the result limit per request.
    localparam int USED = (DEPTH < RESULT_LIMIT) ? DEPTH : RESULT_LIMIT;
    localparam int IW   = $clog2(USED);
    localparam int CW   = $clog2(USED + 1);
    localparam int XW   = ((IW + 1) > CW) ? (IW + 1) : CW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [CAP_W-1:0] r_cap;
    logic [IW-1:0]    r_head;
    logic [IW-1:0]    r_tail;
    logic [IW-1:0]    r_walk;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_left;
    logic             r_is_list;
    t_out_item        r_out;
    logic [31:0]      r_rd_data;
    logic [31:0]      r_mem [USED];

    logic [CAP_W-1:0] cap_clamp;
    logic [CW-1:0]    cap_use;
    logic             in_acc;
    logic             out_acc;
    logic             q_full;
    logic             q_empty;
    logic             walk_more;
    logic [IW-1:0]    adv_in;
    logic [IW:0]      adv_sum;
    logic [IW-1:0]    adv_nxt;
    logic             mem_we;
    logic             mem_re;
    logic [IW-1:0]    rd_addr;

    // Clamp the capacity register to the range of slots in use.
    always_comb begin
        if (r_cap == '0) begin
            cap_clamp = CAP_W'(1);
        end else if (r_cap > CAP_W'(USED)) begin
            cap_clamp = CAP_W'(USED);
        end else begin
            cap_clamp = r_cap;
        end
    end
    assign cap_use = cap_clamp[CW-1:0];

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_acc   = o_out_valid && !i_out_stall;
    assign q_full    = (r_count >= cap_use);
    assign q_empty   = (r_count == '0);
    assign walk_more = r_is_list && (r_left > CW'(1));

    // Shared index-advance unit: tail on enqueue, head on dequeue, walk pointer on list.
    always_comb begin
        unique case (r_state)
            S_IDLE:  adv_in = r_tail;
            S_READ:  adv_in = r_head;
            S_OUT:   adv_in = r_walk;
            default: adv_in = r_tail;
        endcase
    end
    assign adv_sum = {1'b0, adv_in} + (IW + 1)'(1);
    assign adv_nxt = (XW'(adv_sum) >= XW'(cap_use)) ? '0 : adv_sum[IW-1:0];

    // Storage port control: write on a successful enqueue, read the head on a request
    // that needs data, read the next slot while walking.
    assign mem_we  = in_acc && (i_in_item.action == ACT_ENQ) && !q_full;
    assign mem_re  = (in_acc && !q_empty &&
                      ((i_in_item.action == ACT_DEQ) || (i_in_item.action == ACT_LIST)))
                     || ((r_state == S_OUT) && out_acc && walk_more);
    assign rd_addr = (r_state == S_OUT) ? adv_nxt : r_head;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= i_in_item.data_in;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Sequencer: state, queue pointers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cap     <= CAP_RESET;
            r_head    <= '0;
            r_tail    <= '0;
            r_walk    <= '0;
            r_count   <= '0;
            r_left    <= '0;
            r_is_list <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in_item.action)
                            ACT_ENQ: begin
                                if (q_full) begin
                                    r_out <= '{status: ST_FULL, data_out: '0, last: 1'b1};
                                end else begin
                                    r_tail  <= adv_nxt;
                                    r_count <= r_count + CW'(1);
                                    r_out   <= '{status: ST_OK, data_out: '0, last: 1'b1};
                                end
                                r_state <= S_OUT;
                            end
                            ACT_DEQ: begin
                                if (q_empty) begin
                                    r_out   <= '{status: ST_EMPTY, data_out: '0, last: 1'b1};
                                    r_state <= S_OUT;
                                end else begin
                                    r_is_list <= 1'b0;
                                    r_left    <= CW'(1);
                                    r_state   <= S_READ;
                                end
                            end
                            ACT_LIST: begin
                                if (q_empty) begin
                                    r_out   <= '{status: ST_EMPTY, data_out: '0, last: 1'b1};
                                    r_state <= S_OUT;
                                end else begin
                                    r_is_list <= 1'b1;
                                    r_left    <= r_count;
                                    r_walk    <= r_head;
                                    r_state   <= S_READ;
                                end
                            end
                            default: begin
                                // Unused code: drop the request, no result.
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_out <= '{status: ST_OK, data_out: r_rd_data, last: (r_left == CW'(1))};
                    if (!r_is_list) begin
                        r_head  <= adv_nxt;
                        r_count <= r_count - CW'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_acc) begin
                        if (walk_more) begin
                            r_walk  <= adv_nxt;
                            r_left  <= r_left - CW'(1);
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // A capacity write empties the queue so the indices stay in range.
            if (i_cfg_wr_en) begin
                r_cap   <= i_cfg_wr_data;
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_item  = r_out;

    // Fill level never passes the capacity in use.
    `CQW_ASSERT_IMPL(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= cap_use)
    // No new request is taken while a result is on offer.
    `CQW_ASSERT_IMPL(a_busy_while_out, i_clk, i_rst_n, o_out_valid, o_in_stall)
    // A result without last must belong to a walk with words still to come.
    `CQW_ASSERT_IMPL(a_walk_not_last, i_clk, i_rst_n, o_out_valid && !o_out_item.last,
                     r_is_list && (r_left > CW'(1)))
    // A successful enqueue grows the queue by one word.
    `CQW_ASSERT_NEXT(a_enq_grows, i_clk, i_rst_n, mem_we && !i_cfg_wr_en,
                     r_count == $past(r_count) + CW'(1))

endmodule
